// ===== sv/tlbw_pkg.sv =====
// Shared types, constants and helper functions for the TLB page walk block.
package tlbw_pkg;

  // Number of TLB entries and the width of an entry index.
  localparam int TLB_ENTRIES = 64;
  localparam int TLB_IDX_W   = $clog2(TLB_ENTRIES);

  // Address geometry for 4 KiB pages with a two-level table.
  localparam int ADDR_W   = 32;
  localparam int OFFS_W   = 12;
  localparam int PAGE_W   = ADDR_W - OFFS_W;
  localparam int DIR_W    = 10;
  localparam int LFSR_W   = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = PAGE_W;
  localparam int KIND_W   = 2;

  typedef logic [TLB_IDX_W-1:0] idx_t;
  typedef logic [PAGE_W-1:0]    page_t;
  typedef logic [LFSR_W-1:0]    lfsr_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_DIR_BASE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSLATE_ENABLE = 1'b1;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_PHYS  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_FAULT = 2'd2
  } kind_t;

  // Page walk progress.
  typedef enum logic [1:0] {
    PHASE_IDLE = 2'd0,
    PHASE_DIR  = 2'd1,
    PHASE_TAB  = 2'd2
  } phase_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic match_en;
    logic lookup;
    logic commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_result;
    logic out_busy;
  } dp_status_t;

  // Victim index for an LFSR value: the value modulo the TLB size, as a table.
  function automatic idx_t victim_index(input lfsr_t v);
    idx_t r;
    r = '0;
    for (int i = 0; i < (1 << LFSR_W); i++) begin
      if (v == LFSR_W'(i)) begin
        r = TLB_IDX_W'(i % TLB_ENTRIES);
      end
    end
    return r;
  endfunction

  // One step of the x^6 + x^5 + 1 LFSR; the all-zero state is never kept.
  function automatic lfsr_t lfsr_advance(input lfsr_t v);
    lfsr_t n;
    n = {v[LFSR_W-2:0], v[LFSR_W-1] ^ v[LFSR_W-2]};
    if (n == '0) begin
      n = lfsr_t'(1);
    end
    return n;
  endfunction

endpackage

// ===== sv/tlbw_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tlbw_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/tlbw_ctrl.sv =====
// Controller state machine that sequences capture, tag match, frame read and commit.
module tlbw_ctrl import tlbw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MATCH = 4'b0010,
    S_LOOK  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   can_commit;

  // A result may be committed once the output register can take it.
  assign can_commit = !status.has_result || !status.out_busy;

  // Next state and command decode.
  always_comb begin
    state_next   = state;
    in_stall     = 1'b1;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_MATCH;
        end
      end
      S_MATCH: begin
        cmd.match_en = 1'b1;
        state_next   = S_LOOK;
      end
      S_LOOK: begin
        cmd.lookup = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (can_commit) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/tlbw_dpath.sv =====
// Datapath: configuration, TLB tags and frames, walk state, victim LFSR and output register.
module tlbw_dpath import tlbw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  output dp_status_t            status,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  mode,
  input  logic [ADDR_W-1:0]     lin_addr,
  input  logic [ADDR_W-1:0]     read_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [KIND_W-1:0]     kind,
  output logic [ADDR_W-1:0]     out_addr
);

  // Configuration registers.
  page_t page_dir_base;
  logic  translate_enable;

  // Captured input word.
  logic              item_mode;
  logic [ADDR_W-1:0] item_lin;
  logic [ADDR_W-1:0] item_word;

  // TLB tag side, held in flops for the parallel compare.
  logic [TLB_ENTRIES-1:0] entry_valid;
  page_t                  entry_tag [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] match;
  logic                   hit;
  idx_t                   hit_idx;
  page_t                  frame_q;

  // Walk state and victim choice.
  phase_t            walk_phase;
  phase_t            walk_phase_next;
  logic [ADDR_W-1:0] walk_lin_addr;
  logic [ADDR_W-1:0] walk_lin_addr_next;
  lfsr_t             victim_lfsr;
  idx_t              victim;
  logic              fill;
  logic              fill_now;

  // Result of the current word.
  logic              res_valid;
  kind_t             res_kind;
  logic [ADDR_W-1:0] res_addr;

  // Output register.
  kind_t             out_kind;
  logic [ADDR_W-1:0] out_addr_q;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      page_dir_base    <= '0;
      translate_enable <= 1'b0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_PAGE_DIR_BASE:    page_dir_base    <= cfg_data;
        REG_TRANSLATE_ENABLE: translate_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Capture the accepted input word.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_mode <= mode;
      item_lin  <= lin_addr;
      item_word <= read_word;
    end
  end

  // Compare every entry against the page number and register the match vector.
  always_ff @(posedge clk) begin
    if (cmd.match_en) begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        match[i] <= entry_valid[i] && (entry_tag[i] == item_lin[ADDR_W-1:OFFS_W]);
      end
    end
  end

  // Lowest-numbered matching entry wins.
  always_comb begin
    hit_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = TLB_IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit <= |match;
    end
  end

  // Frame numbers live in RAM; read at lookup, written on a fill.
  assign victim   = victim_index(victim_lfsr);
  assign fill_now = cmd.commit && fill;

  tlbw_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (TLB_ENTRIES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (fill_now),
    .waddr (victim),
    .wdata (item_word[ADDR_W-1:OFFS_W]),
    .re    (cmd.lookup),
    .raddr (hit_idx),
    .rdata (frame_q)
  );

  // Result of the captured word, and the walk state it leaves.
  always_comb begin
    res_valid          = 1'b0;
    res_kind           = KIND_PHYS;
    res_addr           = item_lin;
    walk_phase_next    = walk_phase;
    walk_lin_addr_next = walk_lin_addr;
    fill               = 1'b0;
    if (!item_mode) begin
      // Translation request; ignored while a walk is in progress.
      if (walk_phase == PHASE_IDLE) begin
        res_valid = 1'b1;
        if (!translate_enable) begin
          res_addr = item_lin;
        end else if (hit) begin
          res_addr = {frame_q, item_lin[OFFS_W-1:0]};
        end else begin
          res_kind           = KIND_READ;
          res_addr           = {page_dir_base, item_lin[ADDR_W-1:ADDR_W-DIR_W], 2'b00};
          walk_phase_next    = PHASE_DIR;
          walk_lin_addr_next = item_lin;
        end
      end
    end else begin
      // Memory reply; meaningful only during a walk.
      unique case (walk_phase)
        PHASE_IDLE: ;
        PHASE_DIR: begin
          res_valid = 1'b1;
          if (!item_word[0]) begin
            res_kind        = KIND_FAULT;
            res_addr        = walk_lin_addr;
            walk_phase_next = PHASE_IDLE;
          end else begin
            res_kind        = KIND_READ;
            res_addr        = {item_word[ADDR_W-1:OFFS_W],
                               walk_lin_addr[OFFS_W+DIR_W-1:OFFS_W], 2'b00};
            walk_phase_next = PHASE_TAB;
          end
        end
        PHASE_TAB: begin
          res_valid       = 1'b1;
          walk_phase_next = PHASE_IDLE;
          if (!item_word[0]) begin
            res_kind = KIND_FAULT;
            res_addr = walk_lin_addr;
          end else begin
            fill     = 1'b1;
            res_addr = {item_word[ADDR_W-1:OFFS_W], walk_lin_addr[OFFS_W-1:0]};
          end
        end
        default: begin
          walk_phase_next = PHASE_IDLE;
        end
      endcase
    end
  end

  // Walk state, valid bits and victim LFSR change only on commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_phase    <= PHASE_IDLE;
      walk_lin_addr <= '0;
      entry_valid   <= '0;
      victim_lfsr   <= lfsr_t'(1);
    end else if (cmd.commit) begin
      walk_phase    <= walk_phase_next;
      walk_lin_addr <= walk_lin_addr_next;
      if (fill) begin
        entry_valid[victim] <= 1'b1;
        victim_lfsr         <= lfsr_advance(victim_lfsr);
      end
    end
  end

  // Tags need no reset: an entry is only compared once its valid bit is set.
  always_ff @(posedge clk) begin
    if (fill_now) begin
      entry_tag[victim] <= walk_lin_addr[ADDR_W-1:OFFS_W];
    end
  end

  // Output register, loaded on commit and emptied when the word is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit && res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && res_valid) begin
      out_kind   <= res_kind;
      out_addr_q <= res_addr;
    end
  end

  assign kind     = out_kind;
  assign out_addr = out_addr_q;

  // Status to the controller.
  assign status.has_result = res_valid;
  assign status.out_busy   = out_valid && out_stall;

endmodule

// ===== sv/tlb_page_walk_translation.sv =====
// A result word is loaded into the output register at the commit step, after the capture,
// tag match and frame RAM read of its input word. A new input word is accepted only once
// the previous one is committed; a stalled output register holds back the commit step.
// A miss costs two more input words (directory and table replies) through memory.
// Reset clears the configuration, all TLB valid bits and the walk, and loads the
// victim LFSR with one; it takes effect at once, with no clearing pass.
module tlb_page_walk_translation import tlbw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  mode,
  input  logic [ADDR_W-1:0]     lin_addr,
  input  logic [ADDR_W-1:0]     read_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [KIND_W-1:0]     kind,
  output logic [ADDR_W-1:0]     out_addr
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer.
  tlbw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Translation datapath.
  tlbw_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mode         (mode),
    .lin_addr     (lin_addr),
    .read_word    (read_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .out_addr     (out_addr)
  );

endmodule
